FILE: rtl/hpoc_pkg.sv
`default_nettype none
package hpoc_pkg;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW = 8;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MMCO5 = 2'd1;
  localparam logic [1:0] ST_BAD_TYPE = 2'd2;
  localparam logic [2:0] REG_POC_TYPE = 3'd0;
  localparam logic [2:0] REG_LSB_LOG2 = 3'd1;
  localparam logic [2:0] REG_FN_LOG2 = 3'd2;
  localparam logic [2:0] REG_FRAMES = 3'd3;
  localparam logic [2:0] REG_NON_REF = 3'd4;
  localparam logic [2:0] REG_T2B = 3'd5;
  localparam logic [2:0] MMCO_RESET_ALL = 3'd5;

  // Previous reference picture state, held as one memory word.
  typedef struct packed {
    logic [31:0] msb;
    logic [15:0] lsb;
    logic [31:0] frame_offset;
    logic [15:0] frame_number;
    logic [2:0]  mmco;
  } prev_t;

  localparam int PREV_W = $bits(prev_t);

  function automatic logic [16:0] pow2_of(input logic [3:0] less4);
    logic [3:0] e;
    e = (less4 > 4'd12) ? 4'd12 : less4;
    return 17'(17'd1 << ({1'b0, e} + 5'd4));
  endfunction
endpackage
`default_nettype wire

FILE: rtl/hpoc_ram.sv
`default_nettype none
module hpoc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/hpoc_divider.sv
`default_nettype none
// Unsigned 32/8 restoring divider, one quotient bit a cycle.
module hpoc_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [7:0]  divisor,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [7:0]       remainder
);
  logic [5:0]  count;
  logic        busy;
  logic [31:0] quo;
  logic [8:0]  rem;
  logic [8:0]  trial;

  assign trial = {rem[7:0], quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 6'd32;
      end else if (busy) begin
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem[7:0];
endmodule
`default_nettype wire

FILE: rtl/h264_picture_order_count.sv
`default_nettype none
// H.264 picture order count unit (types 0, 1 and 2).
// Input channel: one beat per slice header (operation 1) or per cycle table
// load (operation 0); every beat yields exactly one result beat.
// Output channel: top_count, bottom_count and status, held in an output
// register until the receiver drops stall.
// Config channel: valid/ready write of cfg_index/cfg_data; write only while
// idle. ready is always high.
// A load, type 0, type 2 and the invalid type pass S_READ, S_DECIDE and S_OUT;
// type 1 adds the table walks (one table read a cycle for the cycle sum and
// the partial sum) and the 32-step bit-serial divide with its handshake.
// One item is in work at a time; input stall is high while busy or while a
// result waits, and the next beat is taken in the cycle after the result leaves.
// Reset clears the configuration registers, the previous-picture memory word
// (through its valid flag) and the controller. The cycle table is not cleared:
// entries must be loaded before type 1 reads them.
module h264_picture_order_count
  import hpoc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic        is_idr,
  input  wire logic        is_reference,
  input  wire logic [1:0]  picture_structure,
  input  wire logic [15:0] poc_lsb,
  input  wire logic signed [31:0] delta_bottom,
  input  wire logic [15:0] frame_number,
  input  wire logic signed [31:0] delta_first,
  input  wire logic signed [31:0] delta_second,
  input  wire logic [2:0]  first_mmco,
  input  wire logic [7:0]  table_index,
  input  wire logic signed [31:0] table_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] top_count,
  output logic signed [31:0] bottom_count,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_DECIDE = 4'd2,
    S_SUM = 4'd3, S_DIV = 4'd4, S_DIVW = 4'd5, S_PART = 4'd6, S_MUL = 4'd7,
    S_FIN = 4'd8, S_OUT = 4'd9;

  // configuration
  logic [1:0]  poc_type;
  logic [3:0]  lsb_log2, fn_log2;
  logic [7:0]  frames;
  logic [31:0] non_ref, t2b;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      poc_type <= '0; lsb_log2 <= '0; fn_log2 <= '0;
      frames <= '0; non_ref <= '0; t2b <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POC_TYPE: poc_type <= cfg_data[1:0];
        REG_LSB_LOG2: lsb_log2 <= cfg_data[3:0];
        REG_FN_LOG2:  fn_log2 <= cfg_data[3:0];
        REG_FRAMES:   frames <= cfg_data[7:0];
        REG_NON_REF:  non_ref <= cfg_data;
        REG_T2B:      t2b <= cfg_data;
        default: ;
      endcase
    end
  end

  // captured item
  logic        op, idr, isref;
  logic [1:0]  ps;
  logic [15:0] lsb_in, fn_in;
  logic [31:0] dbot, d0, d1, tval;
  logic [2:0]  mmco;
  logic [7:0]  tidx;

  logic [3:0]  state;
  logic        accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= operation; idr <= is_idr; isref <= is_reference;
      ps <= picture_structure; lsb_in <= poc_lsb; fn_in <= frame_number;
      dbot <= delta_bottom; d0 <= delta_first; d1 <= delta_second;
      mmco <= first_mmco; tidx <= table_index; tval <= table_value;
    end
  end

  // previous-picture state: word 0 of a two-word memory, read per item, written back by reference slices
  prev_t prev_rd, prev_wr, prev;
  logic  prev_we, prev_valid;
  hpoc_ram #(.WIDTH(PREV_W), .DEPTH(2)) u_prev (
    .clk(clk), .we(prev_we), .waddr(1'b0), .wdata(prev_wr),
    .raddr(1'b0), .rdata(prev_rd));
  always_ff @(posedge clk) begin
    if (rst) prev_valid <= 1'b0;
    else if (prev_we) prev_valid <= 1'b1;
  end
  assign prev = prev_valid ? prev_rd : '0;

  // cycle table
  logic        tab_we;
  logic [7:0]  tab_ra;
  logic [31:0] tab_rd;
  hpoc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tidx[TABLE_AW-1:0]), .wdata(tval),
    .raddr(tab_ra), .rdata(tab_rd));

  // derived values
  logic [16:0] maxl, maxf;
  logic [15:0] lsb, fn;
  logic [31:0] fo;
  logic        field, bottom;
  assign maxl = pow2_of(lsb_log2);
  assign maxf = pow2_of(fn_log2);
  assign lsb = lsb_in & 16'(maxl - 17'd1);
  assign fn = fn_in & 16'(maxf - 17'd1);
  assign field = (ps != 2'd0);
  assign bottom = ps[1];
  always_comb begin
    fo = (prev.mmco == MMCO_RESET_ALL) ? 32'd0 : prev.frame_offset;
    if (prev.frame_number > fn) fo = fo + {15'd0, maxf};
    if (idr) fo = '0;
  end

  // type 0 msb
  logic [31:0] pm, msb0, cnt0;
  logic [15:0] pl;
  logic [16:0] half;
  always_comb begin
    pm = idr ? 32'd0 : prev.msb;
    pl = idr ? 16'd0 : prev.lsb;
    half = {1'b0, maxl[16:1]};
    if (lsb < pl && {1'b0, pl - lsb} >= half) msb0 = pm + {15'd0, maxl};
    else if (lsb > pl && {1'b0, lsb - pl} > half) msb0 = pm - {15'd0, maxl};
    else msb0 = pm;
    cnt0 = msb0 + {16'd0, lsb};
  end

  // type 1 sequencing
  logic [31:0] absn, per, expected, quo;
  logic [7:0]  i, pos, rem;
  logic        div_start, div_done;
  logic [31:0] a_div, fo_q;
  hpoc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a_div),
    .divisor(frames), .done(div_done), .quotient(quo), .remainder(rem));
  assign a_div = absn - 32'd1;
  assign tab_ra = i;

  logic [31:0] top_r, bot_r, t2;
  logic [1:0]  st_r;

  // type 2: twice the sum of frame offset and frame number, one less for non-reference
  assign t2 = idr ? 32'd0 : ({fo[30:0], 1'b0} + {15'd0, fn, 1'b0}
              - (isref ? 32'd0 : 32'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: if (accept) state <= S_READ;
        S_READ: state <= S_DECIDE;     // memory word now valid
        S_DECIDE: begin
          state <= S_OUT;
          if (!op) begin
            top_r <= '0; bot_r <= '0; st_r <= ST_OK;
          end else if (poc_type == 2'd0) begin
            if (!idr && prev.mmco == MMCO_RESET_ALL) begin
              top_r <= '0; bot_r <= '0; st_r <= ST_MMCO5;
            end else begin
              top_r <= cnt0; bot_r <= field ? cnt0 : cnt0 + dbot; st_r <= ST_OK;
            end
          end else if (poc_type == 2'd2) begin
            top_r <= t2; bot_r <= t2; st_r <= ST_OK;
          end else if (poc_type == 2'd1) begin
            st_r <= ST_OK;
            fo_q <= fo;
            absn <= (frames == 8'd0) ? 32'd0 :
                    ((!isref && $signed(fo + {16'd0, fn}) > 0) ?
                     fo + {16'd0, fn} - 32'd1 : fo + {16'd0, fn});
            expected <= '0;
            per <= '0;
            i <= '0;
            state <= S_FIN;
            if (frames != 8'd0) state <= S_SUM;
          end else begin
            top_r <= '0; bot_r <= '0; st_r <= ST_BAD_TYPE;
          end
        end
        S_SUM: begin
          // absn <= 0 skips the walk entirely
          if ($signed(absn) <= 0) state <= S_FIN;
          else begin
            i <= i + 8'd1;
            state <= S_DIV;
            if (i != 8'd0) per <= per + tab_rd;
          end
          if ($signed(absn) > 0 && i != 8'd0) begin
            if (i - 8'd1 == frames - 8'd1) begin
              per <= per + tab_rd;
              div_start <= 1'b1;
              state <= S_DIVW;
            end else state <= S_SUM;
          end else if ($signed(absn) > 0) state <= S_SUM;
        end
        S_DIVW: if (div_done) begin
          pos <= rem;
          i <= '0;
          state <= S_PART;
        end
        S_PART: begin
          i <= i + 8'd1;
          if (i != 8'd0) begin
            expected <= expected + tab_rd;
            if (i - 8'd1 == pos) state <= S_MUL;
          end
        end
        S_MUL: begin
          expected <= expected + quo * per + (isref ? 32'd0 : non_ref);
          state <= S_FIN;
        end
        S_FIN: begin
          if (!field) begin
            top_r <= expected + d0;
            bot_r <= expected + d0 + t2b + d1;
          end else if (!bottom) begin
            top_r <= expected + d0; bot_r <= expected + d0;
          end else begin
            top_r <= expected + t2b + d0; bot_r <= expected + t2b + d0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // state write-back on the decision cycle (types 0, 2) or finish (type 1); table load on the decision cycle
  always_comb begin
    prev_wr = prev;
    prev_we = 1'b0;
    tab_we = (state == S_DECIDE) && !op;
    if (state == S_DECIDE && op && isref) begin
      if (poc_type == 2'd0 && !(!idr && prev.mmco == MMCO_RESET_ALL)) begin
        prev_we = 1'b1;
        prev_wr.msb = msb0; prev_wr.lsb = lsb; prev_wr.mmco = mmco;
      end else if (poc_type == 2'd2) begin
        prev_we = 1'b1;
        prev_wr.frame_offset = fo; prev_wr.frame_number = fn; prev_wr.mmco = mmco;
      end
    end
    if (state == S_FIN && isref) begin
      prev_we = 1'b1;
      prev_wr.frame_offset = fo_q; prev_wr.frame_number = fn; prev_wr.mmco = mmco;
    end
  end

  assign top_count = top_r;
  assign bottom_count = bot_r;
  assign status = st_r;

  a_one_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result outside output state");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result waits");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(top_count))
    else $error("result dropped");
endmodule
`default_nettype wire
